### rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, types and cell interface structs for the LFU replacement cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAPACITY  = 8;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W     = $clog2(CAPACITY + 1);
  localparam int SLOT_W    = 3;
  localparam int OCC_OUT_W = 4;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;

  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};
  localparam cnt_t CNT_ONE = cnt_t'(1);

  typedef struct packed {
    logic vld;
    key_t key;
    cnt_t cnt;
  } entry_t;

  // running scan passed from cell to cell: first match and first lowest count
  typedef struct packed {
    logic found;
    idx_t found_idx;
    cnt_t found_cnt;
    logic have_min;
    cnt_t min_cnt;
    idx_t min_idx;
    key_t min_key;
  } scan_t;

  typedef struct packed {
    logic commit;
    logic hit;
    idx_t hit_idx;
    idx_t top;
  } ctrl_t;

endpackage

### rtl/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// One cache slot: key, use count and valid flag, with its stage of the
// match / minimum scan and a load path from the neighbor below.
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  idx_t   my_idx,
  input  key_t   look_key,
  input  entry_t prev,
  input  scan_t  scan_in,
  input  ctrl_t  ctrl,
  output entry_t cur,
  output scan_t  scan_out,
  output logic   match
);

  logic vld;
  key_t key;
  cnt_t cnt;
  logic shift;
  logic inc;
  logic take_min;

  assign cur   = '{vld: vld, key: key, cnt: cnt};
  assign match = vld && (key == look_key);

  assign take_min = vld && (!scan_in.have_min || (cnt < scan_in.min_cnt));

  always_comb begin
    scan_out = scan_in;
    if (!scan_in.found && match) begin
      scan_out.found     = 1'b1;
      scan_out.found_idx = my_idx;
      scan_out.found_cnt = cnt;
    end
    if (take_min) begin
      scan_out.have_min = 1'b1;
      scan_out.min_cnt  = cnt;
      scan_out.min_idx  = my_idx;
      scan_out.min_key  = key;
    end
  end

  assign shift = ctrl.commit && !ctrl.hit && (my_idx <= ctrl.top);
  assign inc   = ctrl.commit && ctrl.hit && (my_idx == ctrl.hit_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      cnt <= '0;
    end else if (shift) begin
      vld <= prev.vld;
      cnt <= prev.cnt;
    end else if (inc && (cnt != CNT_MAX)) begin
      cnt <= cnt + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key <= prev.key;
    end
  end

endmodule

### rtl/lfu_replacement_cache.sv
// ----------------------------------------------------------------------------
// lfu_replacement_cache
// Fully associative LFU cache built as a row of slot cells.
// ----------------------------------------------------------------------------
// For each word the key is registered on acceptance; in the update state the
// cell row compares it in every slot, scans for the first match and the first
// lowest count, and shifts or bumps the slots while the result is loaded into
// the output register. No new key is taken during the update, but the result
// register frees the input side, so the next key can be taken while a result
// waits; the update holds only if the previous result has not yet been taken.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module lfu_replacement_cache import lfu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [SLOT_W-1:0]    slot,
  output logic                 evicted,
  output logic signed [31:0]   evicted_key,
  output logic [15:0]          use_count,
  output logic [OCC_OUT_W-1:0] occupancy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic                state;
  key_t                look_key;
  occ_t                occ;
  occ_t                occ_next;
  logic                full;
  logic                commit;
  ctrl_t               ctrl;
  scan_t               scan [CAPACITY+1];
  entry_t              ent [CAPACITY];
  entry_t              new_ent;
  logic [CAPACITY-1:0] match_vec;
  scan_t               last;
  cnt_t                hit_cnt;

  assign in_ready = (state == ST_IDLE);
  assign full     = (occ == occ_t'(CAPACITY));
  assign commit   = (state == ST_WORK) && (!out_valid || out_ready);
  assign last     = scan[CAPACITY];
  assign scan[0]  = '0;
  assign new_ent  = '{vld: 1'b1, key: look_key, cnt: CNT_ONE};

  assign ctrl.commit  = commit;
  assign ctrl.hit     = last.found;
  assign ctrl.hit_idx = last.found_idx;
  assign ctrl.top     = full ? last.min_idx : idx_t'(occ);

  assign occ_next = (!last.found && !full) ? occ + occ_t'(1) : occ;
  assign hit_cnt  = (last.found_cnt == CNT_MAX) ? CNT_MAX : last.found_cnt + CNT_ONE;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_idx   (idx_t'(i)),
      .look_key (look_key),
      .prev     ((i == 0) ? new_ent : ent[(i == 0) ? 0 : i-1]),
      .scan_in  (scan[i]),
      .ctrl     (ctrl),
      .cur      (ent[i]),
      .scan_out (scan[i+1]),
      .match    (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (commit) begin
            state <= ST_IDLE;
            occ   <= occ_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      look_key <= key_t'(key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit         <= last.found;
      slot        <= last.found ? SLOT_W'(last.found_idx) : '0;
      evicted     <= !last.found && full;
      evicted_key <= (!last.found && full) ? last.min_key : '0;
      use_count   <= last.found ? hit_cnt : CNT_ONE;
      occupancy   <= OCC_OUT_W'(occ_next);
    end
  end

  // keys are unique among valid slots
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WORK) |-> $onehot0(match_vec))
    else $error("more than one slot matches the key");

  assert property (@(posedge clk) disable iff (rst)
    occ <= occ_t'(CAPACITY))
    else $error("occupancy above capacity");

  assert property (@(posedge clk) disable iff (rst)
    commit && !last.found |=> ent[0].vld && (ent[0].cnt == CNT_ONE))
    else $error("miss did not install the key in slot 0");

  assert property (@(posedge clk) disable iff (rst)
    commit && !last.found && full |=> occ == occ_t'(CAPACITY))
    else $error("eviction changed occupancy");

endmodule

### sim/lfu_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_checker
// Watches both channels of the LFU cache, keeps its own copy of the slot
// contents and use counts, predicts the result word for every accepted key
// and compares each returned word field by field, oldest first.
// ----------------------------------------------------------------------------
module lfu_cache_checker import lfu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [31:0]   key,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 hit,
  input  logic [SLOT_W-1:0]    slot,
  input  logic                 evicted,
  input  logic signed [31:0]   evicted_key,
  input  logic [15:0]          use_count,
  input  logic [OCC_OUT_W-1:0] occupancy,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted;
    key_t                 evicted_key;
    cnt_t                 use_count;
    logic [OCC_OUT_W-1:0] occupancy;
  } lookup_t;

  key_t    stored_key [CAPACITY];
  cnt_t    stored_cnt [CAPACITY];
  int      fill;
  lookup_t expected_words [$];
  int      fail_cnt = 0;

  assign errors = fail_cnt;

  function automatic lookup_t lookup_and_update(input key_t k);
    lookup_t r;
    int      idx;
    int      victim;
    bit      found;
    r = '0;
    found = 1'b0;
    idx = 0;
    for (int i = 0; i < fill; i++) begin
      if (!found && stored_key[i] == k) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (found) begin
      if (stored_cnt[idx] != CNT_MAX) stored_cnt[idx] = stored_cnt[idx] + CNT_ONE;
      r.hit = 1'b1;
      r.slot = SLOT_W'(idx);
      r.use_count = stored_cnt[idx];
    end else begin
      if (fill >= CAPACITY) begin
        // first slot with the lowest count goes
        victim = 0;
        for (int i = 1; i < fill; i++) begin
          if (stored_cnt[i] < stored_cnt[victim]) victim = i;
        end
        r.evicted = 1'b1;
        r.evicted_key = stored_key[victim];
      end else begin
        victim = fill;
        fill++;
      end
      for (int i = victim; i > 0; i--) begin
        stored_key[i] = stored_key[i-1];
        stored_cnt[i] = stored_cnt[i-1];
      end
      stored_key[0] = k;
      stored_cnt[0] = CNT_ONE;
      r.use_count = CNT_ONE;
    end
    r.occupancy = OCC_OUT_W'(fill);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    lookup_t want;
    if (rst) begin
      fill = 0;
      for (int i = 0; i < CAPACITY; i++) begin
        stored_key[i] = '0;
        stored_cnt[i] = '0;
      end
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          want = expected_words.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("evicted", 32'(want.evicted), 32'(evicted));
          check_field("evicted_key", want.evicted_key, evicted_key);
          check_field("use_count", 32'(want.use_count), 32'(use_count));
          check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
        end
      end
      if (in_valid && in_ready) expected_words.push_back(lookup_and_update(key));
    end
    pending <= expected_words.size();
  end

endmodule

### sim/lfu_replacement_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_replacement_cache_tb
// Drives keys into the LFU cache: a directed run over extreme keys, ties and
// evictions, then random keys drawn mostly from a small hot pool, with random
// gaps and output stalls.
// ----------------------------------------------------------------------------
module lfu_replacement_cache_tb;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 1600;
  localparam int LONG_HOLD    = 300;
  localparam int POOL_SIZE    = 12;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [31:0]   key;
  logic                 out_valid;
  logic                 out_ready;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  logic                 evicted;
  logic signed [31:0]   evicted_key;
  logic [15:0]          use_count;
  logic [OCC_OUT_W-1:0] occupancy;
  int                   errors;
  int                   pending;

  int cycle_cnt = 0;
  bit tx_steady = 1'b0;
  int hold_req  = 0;
  int hold_done = 0;

  logic signed [31:0] directed_keys [0:19] = '{
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_0002, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0003, 32'h0000_0003, 32'h0000_0004,
    32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0006, 32'h8000_0000
  };

  lfu_replacement_cache i_dut (
    .clk, .rst, .in_valid, .in_ready, .key, .out_valid, .out_ready,
    .hit, .slot, .evicted, .evicted_key, .use_count, .occupancy
  );

  lfu_cache_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .key, .out_valid, .out_ready,
    .hit, .slot, .evicted, .evicted_key, .use_count, .occupancy,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic signed [31:0] k);
    int n;
    n = tx_steady ? 0 : pick_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // result side
  initial begin : receiver
    int r;
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = hold_req;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 10);
        end else begin
          out_ready <= 1'b0;
          if (r < 85)      n = $urandom_range(1, 2);
          else if (r < 97) n = $urandom_range(3, 12);
          else             n = $urandom_range(20, 60);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic signed [31:0] pool [POOL_SIZE];
    logic signed [31:0] k;
    int                 r;
    rst <= 1'b1;
    in_valid <= 1'b0;
    key <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_keys[i]) send_word(directed_keys[i]);

    foreach (pool[i]) pool[i] = $urandom;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      tx_steady = (i % 400) >= 300;
      if (i == 300) hold_req++;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        k = pool[$urandom_range(0, 3)];
      end else if (r < 80) begin
        k = pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 90) begin
        r = $urandom_range(0, POOL_SIZE - 1);
        pool[r] = $urandom;
        k = pool[r];
      end else begin
        k = $urandom;
      end
      send_word(k);
    end
    in_valid <= 1'b0;

    // let the checker log the last accepted word before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
